// ===== hdl/cmdt_pkg.sv =====
// Shared widths, register indexes and reset values of the class majority debounce tracker.
`timescale 1ns / 1ps

package cmdt_pkg;

  localparam int CLASS_W    = 3;
  localparam int CONF_W     = 8;
  localparam int TS_W       = 48;
  localparam int TDATA_W    = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // tdata bit positions, lowest field first
  localparam int CLASS_LSB = 0;
  localparam int CONF_LSB  = CLASS_LSB + CLASS_W;
  localparam int TS_LSB    = CONF_LSB + CONF_W;
  localparam int USED_W    = TS_LSB + TS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_FRAMES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_FRAMES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_TIMEOUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONFIDENCE = 3'd4;

  localparam logic [4:0]  RST_WINDOW_LENGTH  = 5'd5;
  localparam logic [7:0]  RST_CONFIRM_FRAMES = 8'd3;
  localparam logic [7:0]  RST_CHANGE_FRAMES  = 8'd3;
  localparam logic [15:0] RST_LOST_TIMEOUT   = 16'd500;
  // 0.1 in Q0.8, rounded
  localparam logic [7:0]  RST_MIN_CONFIDENCE = 8'd26;

  localparam logic [7:0]  COUNT_MAX = 8'd255;

endpackage

// ===== hdl/cmdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cmdt_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== hdl/class_majority_debounce_tracker.sv =====
// Top level: sliding-window majority vote with a debounce mode machine on top.
`timescale 1ns / 1ps

// Usage
// in_*  : one detection per request; tdata = class, confidence, timestamp (ms).
// out_* : exactly one result per request; tdata = class, confidence, timestamp.
// cfg_* : register writes (window length, confirm frames, change frames,
//         lost timeout, minimum confidence), only while the block is idle.
// Each request is written into the window RAM, then the newest "fill" codes
// are read back one a cycle into a per-class tally, then the tallies are
// scanned one a cycle with a single comparator for the majority (ties go to
// the lowest code), and the mode machine decides the result.
// A request holds in_tready low from acceptance until its result is registered;
// the read pass covers fill codes, fill being the current window occupancy
// (at most MAX_WINDOW), then the scan covers all CLASS_COUNT tallies.
// The result sits in an output register; a new request is taken while it
// waits, and the next result is held back until the receiver takes it.
// Reset (synchronous, rst_n low) returns to idle mode with an empty window
// and the register reset values; no clearing pass is needed.

module class_majority_debounce_tracker
  import cmdt_pkg::*;
#(
  parameter int MAX_WINDOW  = 16,
  parameter int CLASS_COUNT = 8,
  parameter int TIME_BITS   = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] detected_class, [10:3] confidence, [58:11] now_time, [63:59] zero
  input  logic [TDATA_W-1:0]    in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] out_class, [10:3] out_confidence, [58:11] out_time, [63:59] zero
  output logic [TDATA_W-1:0]    out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int HW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FW  = $clog2(MAX_WINDOW + 1);
  localparam int TIW = $clog2(CLASS_COUNT);
  localparam int TB  = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;

  typedef enum logic [1:0] {P_IDLE, P_READ, P_SCAN, P_DONE} phase_t;
  typedef enum logic [2:0] {
    M_IDLE, M_CONFIRMING, M_ACTIVE, M_CHANGING, M_LOST
  } mode_t;

  phase_t phase_r;
  mode_t  mode_r, mode_nxt;

  logic [4:0]  window_length_r;
  logic [7:0]  confirm_frames_r;
  logic [7:0]  change_frames_r;
  logic [15:0] lost_timeout_r;
  logic [7:0]  min_confidence_r;

  logic [HW-1:0] head_r;
  logic [HW-1:0] rd_ptr_r;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] issue_cnt_r;
  logic          rd_vld_r;

  logic [FW-1:0]  tally_r [CLASS_COUNT];
  logic [TIW-1:0] sc_r;
  logic [TIW-1:0] best_r;
  logic [FW-1:0]  best_cnt_r;

  logic [CLASS_W-1:0] cls_r;
  logic [CONF_W-1:0]  conf_r;
  logic [TB-1:0]      now_r;
  logic               det_r;

  logic [7:0]         confirm_count_r, confirm_count_nxt;
  logic [7:0]         change_count_r, change_count_nxt;
  logic [CLASS_W-1:0] pending_r, pending_nxt;
  logic [CLASS_W-1:0] held_class_r, held_class_nxt;
  logic [CONF_W-1:0]  held_conf_r, held_conf_nxt;
  logic [TB-1:0]      last_seen_r, last_seen_nxt;

  logic               out_valid_r;
  logic [CLASS_W-1:0] out_class_r, out_class_nxt;
  logic [CONF_W-1:0]  out_conf_r, out_conf_nxt;
  logic [TS_W-1:0]    out_time_r, out_time_nxt;

  logic               in_accept;
  logic [CLASS_W-1:0] in_cls_raw, in_cls;
  logic [CONF_W-1:0]  in_conf;
  logic [FW-1:0]      eff_len;
  logic [FW:0]        fill_inc;
  logic               issuing;
  logic [CLASS_W-1:0] ram_rdata;
  logic [TIW-1:0]     tidx;
  logic [FW-1:0]      tally_rd;
  logic               out_free;
  logic [CLASS_W-1:0] maj;
  logic [TIME_BITS-1:0] time_diff;
  logic               timed_out;
  logic [7:0]         bumped;

  // ---------------------------------------------------------------------------
  // input side
  assign in_tready  = (phase_r == P_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign in_cls_raw = in_tdata[CLASS_LSB +: CLASS_W];
  assign in_cls     = (32'(in_cls_raw) >= CLASS_COUNT) ? '0 : in_cls_raw;
  assign in_conf    = in_tdata[CONF_LSB +: CONF_W];

  always_comb begin
    if (window_length_r == 5'd0) begin
      eff_len = FW'(1);
    end else if (32'(window_length_r) > MAX_WINDOW) begin
      eff_len = FW'(MAX_WINDOW);
    end else begin
      eff_len = FW'(window_length_r);
    end
  end

  assign fill_inc = {1'b0, fill_r} + 1'b1;
  assign issuing  = (phase_r == P_READ) && (issue_cnt_r != fill_r);

  cmdt_ram #(
    .WIDTH (CLASS_W),
    .DEPTH (MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (in_accept),
    .waddr (head_r),
    .wdata (in_cls),
    .re    (issuing),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // tally read port shared by the count and the scan (the scan seeds from tally_r[0])
  assign tidx     = (phase_r == P_READ) ? TIW'(ram_rdata) : sc_r;
  assign tally_rd = tally_r[tidx];

  // ---------------------------------------------------------------------------
  // mode machine decision, evaluated in P_DONE
  assign out_free  = !out_valid_r || out_tready;
  assign maj       = CLASS_W'(best_r);
  assign time_diff = TIME_BITS'(now_r) - TIME_BITS'(last_seen_r);
  assign timed_out = time_diff > TIME_BITS'(lost_timeout_r);

  always_comb begin
    mode_nxt          = mode_r;
    confirm_count_nxt = confirm_count_r;
    change_count_nxt  = change_count_r;
    pending_nxt       = pending_r;
    held_class_nxt    = held_class_r;
    held_conf_nxt     = held_conf_r;
    last_seen_nxt     = last_seen_r;
    out_class_nxt     = '0;
    out_conf_nxt      = '0;
    out_time_nxt      = '0;
    bumped            = '0;
    if (!det_r) begin
      case (mode_r)
        M_CONFIRMING: begin
          mode_nxt = M_IDLE;
        end
        M_ACTIVE, M_CHANGING: begin
          mode_nxt      = M_LOST;
          last_seen_nxt = now_r;
          out_class_nxt = held_class_r;
          out_conf_nxt  = held_conf_r;
          out_time_nxt  = TS_W'(now_r);
        end
        M_LOST: begin
          out_time_nxt = TS_W'(now_r);
          if (!timed_out) begin
            out_class_nxt = held_class_r;
            out_conf_nxt  = held_conf_r;
          end
        end
        default: begin
        end
      endcase
    end else begin
      last_seen_nxt = now_r;
      case (mode_r)
        M_CONFIRMING: begin
          if (maj == cls_r) begin
            bumped            = (confirm_count_r == COUNT_MAX) ? COUNT_MAX
                                                               : confirm_count_r + 8'd1;
            confirm_count_nxt = bumped;
            if (bumped >= confirm_frames_r) begin
              mode_nxt       = M_ACTIVE;
              held_class_nxt = maj;
              held_conf_nxt  = conf_r;
              out_class_nxt  = maj;
              out_conf_nxt   = conf_r;
              out_time_nxt   = TS_W'(now_r);
            end
          end else begin
            if (confirm_count_r <= 8'd1) begin
              confirm_count_nxt = '0;
              mode_nxt          = M_IDLE;
            end else begin
              confirm_count_nxt = confirm_count_r - 8'd1;
            end
          end
        end
        M_ACTIVE: begin
          if (maj == held_class_r) begin
            held_conf_nxt = conf_r;
          end else begin
            mode_nxt         = M_CHANGING;
            pending_nxt      = maj;
            change_count_nxt = 8'd1;
          end
          out_class_nxt = held_class_nxt;
          out_conf_nxt  = held_conf_nxt;
          out_time_nxt  = TS_W'(now_r);
        end
        M_CHANGING: begin
          if (maj == pending_r) begin
            bumped           = (change_count_r == COUNT_MAX) ? COUNT_MAX
                                                             : change_count_r + 8'd1;
            change_count_nxt = bumped;
            if (bumped >= change_frames_r) begin
              mode_nxt       = M_ACTIVE;
              held_class_nxt = maj;
              held_conf_nxt  = conf_r;
            end
          end else if (maj == held_class_r) begin
            mode_nxt         = M_ACTIVE;
            change_count_nxt = '0;
          end
          out_class_nxt = held_class_nxt;
          out_conf_nxt  = held_conf_nxt;
          out_time_nxt  = TS_W'(now_r);
        end
        default: begin
          mode_nxt          = M_CONFIRMING;
          confirm_count_nxt = 8'd1;
          pending_nxt       = cls_r;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= P_IDLE;
      mode_r           <= M_IDLE;
      window_length_r  <= RST_WINDOW_LENGTH;
      confirm_frames_r <= RST_CONFIRM_FRAMES;
      change_frames_r  <= RST_CHANGE_FRAMES;
      lost_timeout_r   <= RST_LOST_TIMEOUT;
      min_confidence_r <= RST_MIN_CONFIDENCE;
      head_r           <= '0;
      fill_r           <= '0;
      issue_cnt_r      <= '0;
      rd_vld_r         <= 1'b0;
      confirm_count_r  <= '0;
      change_count_r   <= '0;
      pending_r        <= '0;
      held_class_r     <= '0;
      held_conf_r      <= '0;
      last_seen_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH:  window_length_r  <= cfg_wdata[4:0];
          CFG_CONFIRM_FRAMES: confirm_frames_r <= cfg_wdata[7:0];
          CFG_CHANGE_FRAMES:  change_frames_r  <= cfg_wdata[7:0];
          CFG_LOST_TIMEOUT:   lost_timeout_r   <= cfg_wdata;
          CFG_MIN_CONFIDENCE: min_confidence_r <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end

      // a new result replaces one that leaves in the same cycle
      if (phase_r == P_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      rd_vld_r <= issuing;

      case (phase_r)
        P_IDLE: begin
          if (in_accept) begin
            phase_r     <= P_READ;
            cls_r       <= in_cls;
            conf_r      <= in_conf;
            now_r       <= TB'(in_tdata[TS_LSB +: TS_W]);
            det_r       <= (in_cls != '0) && (in_conf >= min_confidence_r);
            rd_ptr_r    <= head_r;
            head_r      <= (32'(head_r) == MAX_WINDOW - 1) ? '0 : head_r + 1'b1;
            fill_r      <= (fill_inc < {1'b0, eff_len}) ? fill_inc[FW-1:0] : eff_len;
            issue_cnt_r <= '0;
            for (int k = 0; k < CLASS_COUNT; k++) begin
              tally_r[k] <= '0;
            end
          end
        end
        P_READ: begin
          if (issuing) begin
            issue_cnt_r <= issue_cnt_r + 1'b1;
            rd_ptr_r    <= (rd_ptr_r == '0) ? HW'(MAX_WINDOW - 1) : rd_ptr_r - 1'b1;
          end
          if (rd_vld_r) begin
            tally_r[tidx] <= tally_rd + 1'b1;
          end else if (!issuing) begin
            phase_r    <= P_SCAN;
            best_r     <= '0;
            best_cnt_r <= tally_r[0];
            sc_r       <= TIW'(1);
          end
        end
        P_SCAN: begin
          if (tally_rd > best_cnt_r) begin
            best_r     <= sc_r;
            best_cnt_r <= tally_rd;
          end
          if (sc_r == TIW'(CLASS_COUNT - 1)) begin
            phase_r <= P_DONE;
          end else begin
            sc_r <= sc_r + 1'b1;
          end
        end
        P_DONE: begin
          if (out_free) begin
            phase_r         <= P_IDLE;
            mode_r          <= mode_nxt;
            confirm_count_r <= confirm_count_nxt;
            change_count_r  <= change_count_nxt;
            pending_r       <= pending_nxt;
            held_class_r    <= held_class_nxt;
            held_conf_r     <= held_conf_nxt;
            last_seen_r     <= last_seen_nxt;
            out_class_r     <= out_class_nxt;
            out_conf_r      <= out_conf_nxt;
            out_time_r      <= out_time_nxt;
          end
        end
        default: begin
          phase_r <= P_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W - USED_W){1'b0}}, out_time_r, out_conf_r, out_class_r};

endmodule

// ===== hdl/cmdt_checker.sv =====
// Port-level checker for the class majority debounce tracker, with its bind.
`timescale 1ns / 1ps

module cmdt_checker
  import cmdt_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic [TDATA_W-1:0] in_tdata,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // one request at a time: ready drops after every accepted request
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one still in work");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // padding above the packed fields stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TDATA_W-1:USED_W] == '0)
    else $error("padding bits of result set");

  // a result appears as the request finishes, so the input is free again
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result raised while request still in work");

endmodule

bind class_majority_debounce_tracker cmdt_checker u_cmdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
